@@ rtl/rgbd_pkg.sv @@
// Shared constants, types and state codes for the RGB distance similarity unit.
`timescale 1ns / 1ps

package rgbd_pkg;

   localparam int unsigned CHAN_W      = 8;
   localparam int unsigned SQ_SUM_W    = 18;   // 3 * 255 * 255 = 195075
   localparam int unsigned FRAC_SHIFT  = 16;
   localparam int unsigned RADICAND_W  = SQ_SUM_W + FRAC_SHIFT;
   localparam int unsigned DIST_W      = 17;   // floor(sqrt(195075 << 16)) = 113068
   localparam int unsigned ACC_W       = 40;
   localparam int unsigned CNT_W       = 23;
   localparam int unsigned SIM_W       = 17;
   localparam int unsigned MAXV_W      = CNT_W + DIST_W;

   localparam int unsigned MAX_PIXELS  = 4194304;
   localparam int unsigned CNT_FIELD_MAX = (1 << CNT_W) - 1;
   localparam int unsigned CNT_LIMIT   =
      (MAX_PIXELS < CNT_FIELD_MAX) ? MAX_PIXELS : CNT_FIELD_MAX;

   localparam int unsigned CHANNEL_SQ_MAX  = 255 * 255 * 3;
   localparam int unsigned SQRT_MAX_SUM    = 441;  // floor(sqrt(CHANNEL_SQ_MAX))
   localparam int unsigned DIST_FULL_SCALE = SQRT_MAX_SUM * 256;

   localparam int unsigned DIV_STEPS   = SIM_W;
   localparam int unsigned STEP_W      = $clog2(DIV_STEPS);

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SQ_SUM_W-1:0] sq_sum;
      logic                final_pixel;
   } qentry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstatus_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROOT,
      BK_ACCUM,
      BK_SCALE,
      BK_PREP,
      BK_DIVIDE,
      BK_OUTPUT
   } back_state_type;

endpackage

@@ rtl/rgbd_channels.sv @@
// Valid/ready channel interfaces for pixel pairs and image results.
`timescale 1ns / 1ps

interface rgbd_req_if;
   logic                         valid;
   logic                         ready;
   logic [rgbd_pkg::CHAN_W-1:0]  ref_red;
   logic [rgbd_pkg::CHAN_W-1:0]  ref_green;
   logic [rgbd_pkg::CHAN_W-1:0]  ref_blue;
   logic [rgbd_pkg::CHAN_W-1:0]  cand_red;
   logic [rgbd_pkg::CHAN_W-1:0]  cand_green;
   logic [rgbd_pkg::CHAN_W-1:0]  cand_blue;
   logic                         final_pixel;

   modport source (output valid, ref_red, ref_green, ref_blue, cand_red, cand_green,
                   cand_blue, final_pixel, input ready);
   modport sink (input valid, ref_red, ref_green, ref_blue, cand_red, cand_green,
                 cand_blue, final_pixel, output ready);
endinterface

interface rgbd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rgbd_pkg::SIM_W-1:0]  similarity;
   logic [rgbd_pkg::ACC_W-1:0]  distance_total;
   logic [rgbd_pkg::CNT_W-1:0]  pixels_seen;

   modport source (output valid, similarity, distance_total, pixels_seen, input ready);
   modport sink (input valid, similarity, distance_total, pixels_seen, output ready);
endinterface

@@ rtl/rgbd_front.sv @@
// Front end: takes pixel pairs and forms the squared colour difference sum.
`timescale 1ns / 1ps

module rgbd_front (
   rgbd_req_if.sink                 req_chan,
   input  rgbd_pkg::qstatus_type    q_status,
   output logic                     push,
   output rgbd_pkg::qentry_type     push_data
);

   function automatic logic [2*rgbd_pkg::CHAN_W-1:0] sq_diff(
      input logic [rgbd_pkg::CHAN_W-1:0] a,
      input logic [rgbd_pkg::CHAN_W-1:0] b
   );
      logic [rgbd_pkg::CHAN_W-1:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return {{rgbd_pkg::CHAN_W{1'b0}}, d} * {{rgbd_pkg::CHAN_W{1'b0}}, d};
   endfunction

   logic [2*rgbd_pkg::CHAN_W-1:0] sq_r, sq_g, sq_b;

   assign sq_r = sq_diff(req_chan.ref_red,   req_chan.cand_red);
   assign sq_g = sq_diff(req_chan.ref_green, req_chan.cand_green);
   assign sq_b = sq_diff(req_chan.ref_blue,  req_chan.cand_blue);

   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && !q_status.full;

   always_comb begin
      push_data.sq_sum      = rgbd_pkg::SQ_SUM_W'(sq_r) + rgbd_pkg::SQ_SUM_W'(sq_g)
                            + rgbd_pkg::SQ_SUM_W'(sq_b);
      push_data.final_pixel = req_chan.final_pixel;
   end

endmodule

@@ rtl/rgbd_queue.sv @@
// Short FIFO that decouples the front end from the distance back end.
`timescale 1ns / 1ps

module rgbd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rgbd_pkg::qentry_type    push_data,
   input  logic                    pop,
   output rgbd_pkg::qentry_type    head,
   output rgbd_pkg::qstatus_type   status
);

   rgbd_pkg::qentry_type entry_ff [rgbd_pkg::QUEUE_DEPTH];

   logic [rgbd_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rgbd_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rgbd_pkg::QUEUE_CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == rgbd_pkg::QUEUE_CW'(rgbd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rgbd_pkg::QUEUE_CW'(rgbd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> !pop)
      else $error("pop from empty queue");

endmodule

@@ rtl/rgbd_back.sv @@
// Back end: iterative square root, accumulation and the final similarity division.
`timescale 1ns / 1ps

module rgbd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rgbd_pkg::qentry_type    head,
   input  rgbd_pkg::qstatus_type   q_status,
   output logic                    pop,
   rgbd_rsp_if.source              rsp_chan
);

   localparam logic [rgbd_pkg::RADICAND_W-1:0] ROOT_BIT_INIT =
      rgbd_pkg::RADICAND_W'(1) << (rgbd_pkg::RADICAND_W - 2);

   rgbd_pkg::back_state_type state_ff, state_in;

   logic [rgbd_pkg::RADICAND_W-1:0] rem_ff, rem_in;
   logic [rgbd_pkg::RADICAND_W-1:0] root_ff, root_in;
   logic [rgbd_pkg::RADICAND_W-1:0] bit_ff;
   logic                            final_ff;
   logic [rgbd_pkg::ACC_W-1:0]      acc_ff, acc_in;
   logic [rgbd_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [rgbd_pkg::MAXV_W-1:0]     maxv_ff;
   logic [rgbd_pkg::MAXV_W-1:0]     div_rem_ff, div_rem_in;
   logic [rgbd_pkg::SIM_W-1:0]      quot_ff;
   logic [rgbd_pkg::STEP_W-1:0]     step_ff;
   logic                            div_ge;

   logic                            rsp_valid_ff;
   logic [rgbd_pkg::SIM_W-1:0]      rsp_sim_ff;
   logic [rgbd_pkg::ACC_W-1:0]      rsp_dist_ff;
   logic [rgbd_pkg::CNT_W-1:0]      rsp_cnt_ff;

   logic out_free;
   logic load_item, root_step, acc_load, scale_load, prep_load, div_step, out_load;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rgbd_pkg::BK_IDLE:   if (!q_status.empty) state_in = rgbd_pkg::BK_ROOT;
         rgbd_pkg::BK_ROOT:   if (bit_ff[0]) state_in = rgbd_pkg::BK_ACCUM;
         rgbd_pkg::BK_ACCUM:  state_in = final_ff ? rgbd_pkg::BK_SCALE : rgbd_pkg::BK_IDLE;
         rgbd_pkg::BK_SCALE:  state_in = rgbd_pkg::BK_PREP;
         rgbd_pkg::BK_PREP:   state_in = rgbd_pkg::BK_DIVIDE;
         rgbd_pkg::BK_DIVIDE: begin
            if (step_ff == rgbd_pkg::STEP_W'(rgbd_pkg::DIV_STEPS - 1)) begin
               state_in = rgbd_pkg::BK_OUTPUT;
            end
         end
         rgbd_pkg::BK_OUTPUT: if (out_free) state_in = rgbd_pkg::BK_IDLE;
         default:             state_in = rgbd_pkg::BK_IDLE;
      endcase
   end

   // controls
   always_comb begin
      load_item  = 1'b0;
      root_step  = 1'b0;
      acc_load   = 1'b0;
      scale_load = 1'b0;
      prep_load  = 1'b0;
      div_step   = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         rgbd_pkg::BK_IDLE:   load_item  = !q_status.empty;
         rgbd_pkg::BK_ROOT:   root_step  = 1'b1;
         rgbd_pkg::BK_ACCUM:  acc_load   = 1'b1;
         rgbd_pkg::BK_SCALE:  scale_load = 1'b1;
         rgbd_pkg::BK_PREP:   prep_load  = 1'b1;
         rgbd_pkg::BK_DIVIDE: div_step   = 1'b1;
         rgbd_pkg::BK_OUTPUT: out_load   = out_free;
         default: ;
      endcase
   end

   assign pop = load_item;

   // one result bit of the root per cycle
   always_comb begin
      logic [rgbd_pkg::RADICAND_W:0] trial;
      trial = {1'b0, root_ff} + {1'b0, bit_ff};
      if ({1'b0, rem_ff} >= trial) begin
         rem_in  = rem_ff - trial[rgbd_pkg::RADICAND_W-1:0];
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end
   end

   always_comb begin
      logic [rgbd_pkg::ACC_W:0] sum;
      sum    = {1'b0, acc_ff} + (rgbd_pkg::ACC_W + 1)'(root_ff[rgbd_pkg::DIST_W-1:0]);
      acc_in = sum[rgbd_pkg::ACC_W] ? '1 : sum[rgbd_pkg::ACC_W-1:0];
      cnt_in = (cnt_ff < rgbd_pkg::CNT_W'(rgbd_pkg::CNT_LIMIT)) ? cnt_ff + 1'b1 : cnt_ff;
   end

   // restoring division; the first step has no shift since the dividend never exceeds maxv
   always_comb begin
      logic [rgbd_pkg::MAXV_W:0] shifted;
      logic [rgbd_pkg::MAXV_W:0] diff;
      shifted    = (step_ff == '0) ? {1'b0, div_rem_ff} : {div_rem_ff, 1'b0};
      diff       = shifted - {1'b0, maxv_ff};
      div_ge     = (shifted >= {1'b0, maxv_ff});
      div_rem_in = div_ge ? diff[rgbd_pkg::MAXV_W-1:0] : shifted[rgbd_pkg::MAXV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgbd_pkg::BK_IDLE;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (acc_load) begin
            acc_ff <= acc_in;
            cnt_ff <= cnt_in;
         end else if (out_load) begin
            acc_ff <= '0;
            cnt_ff <= '0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_item) begin
         rem_ff   <= {head.sq_sum, {rgbd_pkg::FRAC_SHIFT{1'b0}}};
         root_ff  <= '0;
         bit_ff   <= ROOT_BIT_INIT;
         final_ff <= head.final_pixel;
      end else if (root_step) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 2;
      end
      if (scale_load) begin
         maxv_ff <= {{rgbd_pkg::DIST_W{1'b0}}, cnt_ff}
                  * {{rgbd_pkg::CNT_W{1'b0}}, rgbd_pkg::DIST_W'(rgbd_pkg::DIST_FULL_SCALE)};
      end
      if (prep_load) begin
         div_rem_ff <= (rgbd_pkg::MAXV_W'(acc_ff) < maxv_ff)
                     ? maxv_ff - rgbd_pkg::MAXV_W'(acc_ff) : '0;
         quot_ff    <= '0;
         step_ff    <= '0;
      end else if (div_step) begin
         div_rem_ff <= div_rem_in;
         quot_ff    <= {quot_ff[rgbd_pkg::SIM_W-2:0], div_ge};
         step_ff    <= step_ff + 1'b1;
      end
      if (out_load) begin
         rsp_sim_ff  <= quot_ff;
         rsp_dist_ff <= acc_ff;
         rsp_cnt_ff  <= cnt_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.similarity     = rsp_sim_ff;
   assign rsp_chan.distance_total = rsp_dist_ff;
   assign rsp_chan.pixels_seen    = rsp_cnt_ff;

   a_root_bit_onehot: assert property (@(posedge clock) disable iff (reset)
      state_ff == rgbd_pkg::BK_ROOT |-> $onehot(bit_ff))
      else $error("root step bit lost");

   a_clear_after_output: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (acc_ff == '0) && (cnt_ff == '0) && rsp_valid_ff)
      else $error("state not cleared after result");

   a_sim_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_sim_ff <= rgbd_pkg::SIM_W'(1 << rgbd_pkg::FRAC_SHIFT))
      else $error("similarity out of range");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == rgbd_pkg::BK_SCALE |-> cnt_ff != '0)
      else $error("zero pixel count at image end");

endmodule

@@ rtl/rgb_distance_similarity_score_unit.sv @@
// Top level of the RGB distance similarity unit.
`timescale 1ns / 1ps

// Scores a candidate image against a reference, one pixel pair per item. The front end
// takes an item in the cycle it is offered whenever the four-entry queue has room; the
// back end then takes one pair at a time (fetch, bit-serial square root, accumulate)
// and fetches no new pair before the last is accumulated, so the sustained rate is set
// by the square-root unit. The pair flagged final_pixel then goes on through a scale
// multiply, set-up, 17-step division and result load, and yields one result item holding
// the similarity (16 fraction bits), the distance sum and the pixel count; the
// accumulators are then cleared for the next image. A pending result does not hold up
// accumulation of the next image, only the next image's final result.
module rgb_distance_similarity_score_unit (
   input  logic        clock,
   input  logic        reset,
   rgbd_req_if.sink    req_chan,
   rgbd_rsp_if.source  rsp_chan
);

   rgbd_pkg::qentry_type  push_data;
   rgbd_pkg::qentry_type  head;
   rgbd_pkg::qstatus_type q_status;
   logic                  push;
   logic                  pop;

   rgbd_front u_front (
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   rgbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   rgbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

@@ sim/rgbd_score_checker.sv @@
// Scoreboard for the RGB distance similarity unit: predicts each image score and checks it.
`timescale 1ns / 1ps

module rgbd_score_checker (
   input  logic  clock,
   input  logic  reset,
   rgbd_req_if   req_mon,
   rgbd_rsp_if   rsp_mon,
   output int    mismatches,
   output int    scores_pending
);

   typedef struct packed {
      logic [rgbd_pkg::SIM_W-1:0] similarity;
      logic [rgbd_pkg::ACC_W-1:0] distance_total;
      logic [rgbd_pkg::CNT_W-1:0] pixels_seen;
   } image_score_type;

   localparam longint unsigned DIST_SUM_CAP = (64'd1 << rgbd_pkg::ACC_W) - 1;

   image_score_type  scores_due[$];
   longint unsigned  dist_sum;
   longint unsigned  pair_count;
   int               fail_tally;

   // Bitwise search for the largest root whose square does not exceed the radicand.
   function automatic longint unsigned floor_root(input longint unsigned radicand);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = int'(rgbd_pkg::DIST_W); b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand)
            root = trial;
      end
      return root;
   endfunction

   function automatic longint unsigned chan_gap_sq(input logic [rgbd_pkg::CHAN_W-1:0] a,
                                                   input logic [rgbd_pkg::CHAN_W-1:0] b);
      longint unsigned gap;
      gap = (a >= b) ? longint'(a - b) : longint'(b - a);
      return gap * gap;
   endfunction

   task automatic report_mismatch(input string what);
      $display("checker: %0t %s", $time, what);
      fail_tally++;
   endtask

   task automatic predict_pair();
      longint unsigned sq_total;
      longint unsigned pix_dist;
      longint unsigned sum_next;
      longint unsigned cnt_next;
      longint unsigned full_scale;
      longint unsigned score;
      image_score_type rec;
      sq_total = chan_gap_sq(req_mon.ref_red,   req_mon.cand_red)
               + chan_gap_sq(req_mon.ref_green, req_mon.cand_green)
               + chan_gap_sq(req_mon.ref_blue,  req_mon.cand_blue);
      pix_dist = floor_root(sq_total << rgbd_pkg::FRAC_SHIFT);
      sum_next = dist_sum + pix_dist;
      if (sum_next > DIST_SUM_CAP)
         sum_next = DIST_SUM_CAP;
      cnt_next = (pair_count < rgbd_pkg::CNT_LIMIT) ? pair_count + 1 : pair_count;
      if (!req_mon.final_pixel) begin
         dist_sum   = sum_next;
         pair_count = cnt_next;
      end else begin
         full_scale = cnt_next * rgbd_pkg::DIST_FULL_SCALE;
         // distances just over full scale push the sum past the maximum: score floors at 0
         score = (sum_next < full_scale) ? ((full_scale - sum_next) << 16) / full_scale : 0;
         rec.similarity     = score[rgbd_pkg::SIM_W-1:0];
         rec.distance_total = sum_next[rgbd_pkg::ACC_W-1:0];
         rec.pixels_seen    = cnt_next[rgbd_pkg::CNT_W-1:0];
         scores_due.push_back(rec);
         dist_sum   = 0;
         pair_count = 0;
      end
   endtask

   always @(posedge clock) begin
      image_score_type want;
      if (reset) begin
         scores_due.delete();
         dist_sum   = 0;
         pair_count = 0;
         fail_tally = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (scores_due.size() == 0) begin
               report_mismatch("result item with no image outstanding");
            end else begin
               want = scores_due.pop_front();
               if (rsp_mon.similarity !== want.similarity)
                  report_mismatch($sformatf("similarity mismatch: got %0d, expected %0d",
                                            rsp_mon.similarity, want.similarity));
               if (rsp_mon.distance_total !== want.distance_total)
                  report_mismatch($sformatf("distance_total mismatch: got %0d, expected %0d",
                                            rsp_mon.distance_total, want.distance_total));
               if (rsp_mon.pixels_seen !== want.pixels_seen)
                  report_mismatch($sformatf("pixels_seen mismatch: got %0d, expected %0d",
                                            rsp_mon.pixels_seen, want.pixels_seen));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_pair();
      end
      mismatches     <= fail_tally;
      scores_pending <= scores_due.size();
   end

endmodule

@@ sim/tb.sv @@
// Testbench top: drives pixel pairs and result back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb;

   localparam int TOTAL_PAIRS = 725;
   localparam int QUIET_FROM  = 600;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum int {IMG_RANDOM, IMG_NEAR, IMG_OPPOSED, IMG_RAILS} image_kind_type;

   typedef struct {
      logic [rgbd_pkg::CHAN_W-1:0] ref_red;
      logic [rgbd_pkg::CHAN_W-1:0] ref_green;
      logic [rgbd_pkg::CHAN_W-1:0] ref_blue;
      logic [rgbd_pkg::CHAN_W-1:0] cand_red;
      logic [rgbd_pkg::CHAN_W-1:0] cand_green;
      logic [rgbd_pkg::CHAN_W-1:0] cand_blue;
      logic                        final_pixel;
   } pixel_pair_type;

   logic clock;
   logic reset;
   int   mismatches;
   int   scores_pending;
   int   cycle_count;
   int   pairs_sent;
   int   images_sent;
   int   send_idle_pct;
   int   stall_pct;

   rgbd_req_if req_if ();
   rgbd_rsp_if rsp_if ();

   rgb_distance_similarity_score_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   rgbd_score_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatches     (mismatches),
      .scores_pending (scores_pending)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: timed out after %0d cycles", cycle_count);
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic pixel_pair_type pair_of(input int rr, input int rg, input int rb,
                                              input int cr, input int cg, input int cb,
                                              input bit last);
      pixel_pair_type p;
      p.ref_red     = rgbd_pkg::CHAN_W'(rr);
      p.ref_green   = rgbd_pkg::CHAN_W'(rg);
      p.ref_blue    = rgbd_pkg::CHAN_W'(rb);
      p.cand_red    = rgbd_pkg::CHAN_W'(cr);
      p.cand_green  = rgbd_pkg::CHAN_W'(cg);
      p.cand_blue   = rgbd_pkg::CHAN_W'(cb);
      p.final_pixel = last;
      return p;
   endfunction

   function automatic logic [rgbd_pkg::CHAN_W-1:0] near_value(
      input logic [rgbd_pkg::CHAN_W-1:0] v
   );
      int n;
      n = int'(v) + int'($urandom_range(0, 6)) - 3;
      if (n < 0)
         n = 0;
      if (n > 255)
         n = 255;
      return rgbd_pkg::CHAN_W'(n);
   endfunction

   function automatic pixel_pair_type make_pair(input image_kind_type kind, input bit last);
      int ch_ref[3];
      int ch_cand[3];
      for (int c = 0; c < 3; c++) begin
         case (kind)
            IMG_NEAR: begin
               ch_ref[c]  = $urandom_range(0, 255);
               ch_cand[c] = int'(near_value(rgbd_pkg::CHAN_W'(ch_ref[c])));
            end
            IMG_OPPOSED: begin
               // near full-scale difference per channel, direction chosen at random
               ch_ref[c]  = $urandom_range(0, 2);
               ch_cand[c] = $urandom_range(253, 255);
               if ($urandom_range(0, 1)) begin
                  ch_ref[c]  = 255 - ch_ref[c];
                  ch_cand[c] = 255 - ch_cand[c];
               end
            end
            IMG_RAILS: begin
               ch_ref[c]  = $urandom_range(0, 1) ? 255 : 0;
               ch_cand[c] = $urandom_range(0, 1) ? 255 : 0;
            end
            default: begin
               ch_ref[c]  = $urandom_range(0, 255);
               ch_cand[c] = $urandom_range(0, 255);
            end
         endcase
      end
      return pair_of(ch_ref[0], ch_ref[1], ch_ref[2], ch_cand[0], ch_cand[1], ch_cand[2],
                     last);
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic offer_pair(input pixel_pair_type p);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_if.ref_red     <= p.ref_red;
      req_if.ref_green   <= p.ref_green;
      req_if.ref_blue    <= p.ref_blue;
      req_if.cand_red    <= p.cand_red;
      req_if.cand_green  <= p.cand_green;
      req_if.cand_blue   <= p.cand_blue;
      req_if.final_pixel <= p.final_pixel;
      req_if.valid       <= 1'b1;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
      pairs_sent++;
      if (p.final_pixel)
         images_sent++;
   endtask

   task automatic send_image(input image_kind_type kind, input int len);
      for (int i = 0; i < len; i++)
         offer_pair(make_pair(kind, i == len - 1));
   endtask

   // Result back-pressure: random stall bursts while stall_pct is non-zero.
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
      end
   end

   initial begin
      int             len;
      int             pick;
      image_kind_type kind;
      cycle_count        = 0;
      pairs_sent         = 0;
      images_sent        = 0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.ref_red     = '0;
      req_if.ref_green   = '0;
      req_if.ref_blue    = '0;
      req_if.cand_red    = '0;
      req_if.cand_green  = '0;
      req_if.cand_blue   = '0;
      req_if.final_pixel = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: identical, opposite rails, single-channel extremes, over-scale sums
      offer_pair(pair_of(0, 0, 0, 0, 0, 0, 1));
      offer_pair(pair_of(255, 255, 255, 0, 0, 0, 1));
      offer_pair(pair_of(0, 0, 0, 255, 255, 255, 1));
      offer_pair(pair_of(255, 0, 255, 0, 255, 0, 0));
      offer_pair(pair_of(0, 255, 0, 255, 0, 255, 0));
      offer_pair(pair_of(255, 255, 255, 0, 0, 0, 1));
      offer_pair(pair_of(255, 0, 0, 0, 0, 0, 0));
      offer_pair(pair_of(0, 0, 0, 0, 255, 0, 0));
      offer_pair(pair_of(0, 0, 255, 0, 0, 0, 0));
      offer_pair(pair_of(255, 255, 255, 255, 255, 255, 1));
      offer_pair(pair_of(255, 255, 255, 255, 255, 255, 1));
      offer_pair(pair_of(128, 127, 1, 127, 128, 0, 0));
      offer_pair(pair_of(85, 170, 51, 204, 17, 240, 1));
      offer_pair(pair_of(0, 255, 255, 255, 0, 0, 0));
      offer_pair(pair_of(255, 0, 0, 0, 255, 255, 0));
      offer_pair(pair_of(0, 0, 0, 255, 255, 255, 0));
      offer_pair(pair_of(7, 7, 7, 7, 7, 7, 1));

      while (pairs_sent < TOTAL_PAIRS) begin
         if (pairs_sent >= QUIET_FROM) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end else begin
            pick = $urandom_range(0, 3);
            send_idle_pct = (pick < 2) ? 0 : (pick == 2) ? 25 : 60;
            stall_pct     = $urandom_range(0, 1) ? 40 : 0;
         end
         pick = $urandom_range(0, 9);
         kind = (pick < 5) ? IMG_RANDOM : (pick < 7) ? IMG_NEAR :
                (pick < 9) ? IMG_OPPOSED : IMG_RAILS;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 16);
         send_image(kind, len);
      end
      req_if.valid <= 1'b0;

      while (scores_pending != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      $display("tb: %0d pixel pairs in %0d images: directed extremes, then random images",
               pairs_sent, images_sent);
      $display("tb: near-identical, opposed and rail pixels, idling on both sides");
      if (mismatches == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
